// ----- rtl/pwit_pkg.sv -----
// Package: beat types, slot record layout and codes of the wait interval tracker.
`default_nettype none
package pwit_pkg;

  localparam int THREAD_SLOTS = 1024;
  localparam int TID_W        = 23;
  localparam int CFG_W        = 32;

  localparam logic [31:0] MIN_OFFCPU_RST = 32'd100000;

  // register indexes
  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_MIN    = 1'b1;

  // event modes
  localparam logic [1:0] MODE_ENTER  = 2'd0;
  localparam logic [1:0] MODE_EXIT   = 2'd1;
  localparam logic [1:0] MODE_SWITCH = 2'd2;

  // syscall class with no meaning
  localparam logic [1:0] CLASS_NONE = 2'd3;

  // wait reasons; syscall classes map from REASON_SYSCALL_BASE up (lock, sleep, io)
  localparam logic [2:0] REASON_NONE         = 3'd0;
  localparam logic [2:0] REASON_SCHED        = 3'd1;
  localparam logic [2:0] REASON_SYSCALL_BASE = 3'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TID_W-1:0] proc_id;
    logic [TID_W-1:0] thread_id;
    logic [1:0]       wait_class;
    logic [TID_W-1:0] outgoing_tid;
    logic [TID_W-1:0] incoming_tid;
    logic [63:0]      now_ns;
    logic [11:0]      cpu_index;
  } in_beat_t;

  typedef struct packed {
    logic [TID_W-1:0] rec_process;
    logic [TID_W-1:0] rec_thread;
    logic [63:0]      begin_ns;
    logic [63:0]      finish_ns;
    logic [2:0]       wait_reason;
    logic [11:0]      rec_cpu;
    logic [63:0]      accumulated_ns;
  } out_beat_t;

  // one thread slot: class stamps/sums indexed lock, sleep, io
  typedef struct packed {
    logic [2:0][63:0] cls_begin;
    logic [63:0]      switch_begin;
    logic [2:0]       pending_reason;
    logic [2:0][63:0] cls_sum;
    logic [63:0]      offcpu_sum;
  } slot_rec_t;

endpackage
`default_nettype wire

// ----- rtl/pwit_table.sv -----
// Thread table storage: thread id memory and slot record memory.
`default_nettype none
module pwit_table #(
  parameter int SLOTS = pwit_pkg::THREAD_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       tid_re,
  input  wire logic [$clog2(SLOTS)-1:0]   tid_raddr,
  output logic [pwit_pkg::TID_W-1:0]      tid_q,
  input  wire logic                       tid_we,
  input  wire logic [$clog2(SLOTS)-1:0]   tid_waddr,
  input  wire logic [pwit_pkg::TID_W-1:0] tid_wdata,
  input  wire logic                       rec_re,
  input  wire logic [$clog2(SLOTS)-1:0]   rec_raddr,
  output pwit_pkg::slot_rec_t             rec_q,
  input  wire logic                       rec_we,
  input  wire logic [$clog2(SLOTS)-1:0]   rec_waddr,
  input  wire pwit_pkg::slot_rec_t        rec_wdata
);

  logic [pwit_pkg::TID_W-1:0] tid_mem [SLOTS];
  pwit_pkg::slot_rec_t        rec_mem [SLOTS];

  // thread id memory, read data held between reads
  always_ff @(posedge clk) begin
    if (tid_we) begin
      tid_mem[tid_waddr] <= tid_wdata;
    end
    if (tid_re) begin
      tid_q <= tid_mem[tid_raddr];
    end
  end

  // slot record memory
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (rec_re) begin
      rec_q <= rec_mem[rec_raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/per_thread_wait_interval_tracker.sv -----
// Top level: per-thread wait interval tracker with a scanned thread table.
// An ignored event is only accepted. Else an accept, a scan of the used slots up to the match,
// then on a miss allocate or end, else S_READ, S_MOD and for a close S_ACC (RMW).
// A switch scans twice. A close waits in S_ACC while out_stall holds a record.
// Slots fill from the bottom and are never freed, so a fill count replaces valid bits;
// synchronous reset clears it, the state, the target and the output valid, and loads MIN_OFFCPU_RST.
`default_nettype none
module per_thread_wait_interval_tracker #(
  parameter int THREAD_SLOTS = pwit_pkg::THREAD_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire pwit_pkg::in_beat_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output pwit_pkg::out_beat_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [pwit_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(THREAD_SLOTS);
  localparam int CW = $clog2(THREAD_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(THREAD_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_READ = 5'b00100,
    S_MOD  = 5'b01000,
    S_ACC  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [pwit_pkg::TID_W-1:0] target_r;
  logic [31:0]                min_r;
  pwit_pkg::in_beat_t         item_r;
  logic                       phase_r;
  logic [CW-1:0]              fill_r;
  logic [CW-1:0]              ptr_r;
  logic                       cmp_vld_r;
  logic [AW-1:0]              cmp_idx_r;
  logic [AW-1:0]              slot_r;
  logic [63:0]                diff_r;
  logic [63:0]                beg_r;
  logic [2:0]                 reason_r;
  logic                       out_valid_r;
  pwit_pkg::out_beat_t        out_r;

  logic                       tid_re, tid_we, rec_re, rec_we;
  logic [AW-1:0]              tid_raddr, rec_waddr;
  logic [pwit_pkg::TID_W-1:0] tid_q;
  pwit_pkg::slot_rec_t        rec_q, rec_wdata;

  logic [pwit_pkg::TID_W-1:0] key;
  logic [1:0]                 cls;
  logic                       is_enter, is_exit;
  logic                       go, hit, issue, short_dur, emit, load;
  logic [63:0]                total;

  assign cls      = item_r.wait_class;
  assign is_enter = (item_r.mode == pwit_pkg::MODE_ENTER);
  assign is_exit  = (item_r.mode == pwit_pkg::MODE_EXIT);
  assign key      = phase_r ? item_r.incoming_tid :
                    (item_r.mode == pwit_pkg::MODE_SWITCH) ? item_r.outgoing_tid :
                    item_r.thread_id;

  // event filter at accept
  assign go = (target_r != '0) &&
              (((in_data.mode == pwit_pkg::MODE_ENTER) ||
                (in_data.mode == pwit_pkg::MODE_EXIT)) ?
               ((in_data.proc_id == target_r) &&
                (in_data.wait_class != pwit_pkg::CLASS_NONE)) :
               (in_data.mode == pwit_pkg::MODE_SWITCH));

  assign hit       = cmp_vld_r && (tid_q == key);
  assign issue     = (ptr_r < fill_r);
  assign short_dur = (diff_r < {32'd0, min_r});
  assign total     = is_exit ? (rec_q.cls_sum[cls] + diff_r) : (rec_q.offcpu_sum + diff_r);
  assign emit      = is_exit || !short_dur;
  assign load      = (state_r == S_ACC) && emit && !(out_valid_r && out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memory controls and next state
  always_comb begin
    state_nxt = state_r;
    tid_re    = 1'b0;
    tid_raddr = ptr_r[AW-1:0];
    tid_we    = 1'b0;
    rec_re    = 1'b0;
    rec_we    = 1'b0;
    rec_waddr = slot_r;
    rec_wdata = rec_q;
    case (state_r)
      S_IDLE: begin
        if (in_valid && go) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_READ;
        end else if (issue) begin
          tid_re = 1'b1;
        end else if (is_enter) begin
          // allocate lowest free slot with a fresh record
          rec_waddr = fill_r[AW-1:0];
          rec_wdata = '0;
          rec_wdata.cls_begin[cls] = item_r.now_ns;
          rec_wdata.pending_reason = 3'(cls) + pwit_pkg::REASON_SYSCALL_BASE;
          if (fill_r < SLOTS_C) begin
            tid_we = 1'b1;
            rec_we = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (!is_exit && !phase_r) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        rec_re    = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (is_enter) begin
          rec_wdata.cls_begin[cls] = item_r.now_ns;
          rec_wdata.pending_reason = 3'(cls) + pwit_pkg::REASON_SYSCALL_BASE;
          rec_we    = 1'b1;
          state_nxt = S_IDLE;
        end else if (is_exit) begin
          state_nxt = (rec_q.cls_begin[cls] == '0) ? S_IDLE : S_ACC;
        end else if (!phase_r) begin
          // switch-out stamp
          rec_wdata.switch_begin = item_r.now_ns;
          if (rec_q.pending_reason == pwit_pkg::REASON_NONE) begin
            rec_wdata.pending_reason = pwit_pkg::REASON_SCHED;
          end
          rec_we    = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = (rec_q.switch_begin == '0) ? S_IDLE : S_ACC;
        end
      end
      S_ACC: begin
        rec_wdata.pending_reason = pwit_pkg::REASON_NONE;
        if (is_exit) begin
          rec_wdata.cls_begin[cls] = '0;
          rec_wdata.cls_sum[cls]   = total;
        end else begin
          rec_wdata.switch_begin = '0;
          if (!short_dur) rec_wdata.offcpu_sum = total;
        end
        if (!(emit && out_valid_r && out_stall)) begin
          rec_we    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= '0;
      min_r       <= pwit_pkg::MIN_OFFCPU_RST;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == pwit_pkg::CFG_TARGET) begin
          target_r <= cfg_data[pwit_pkg::TID_W-1:0];
        end else begin
          min_r <= cfg_data;
        end
      end
      if (tid_we) fill_r <= fill_r + CW'(1);
      if (state_r == S_SCAN) begin
        cmp_vld_r <= !hit && issue;
      end else begin
        cmp_vld_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // work registers of the event in flight
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r  <= in_data;
        phase_r <= 1'b0;
        ptr_r   <= '0;
      end
      S_SCAN: begin
        if (hit) begin
          slot_r <= cmp_idx_r;
        end else if (issue) begin
          cmp_idx_r <= ptr_r[AW-1:0];
          ptr_r     <= ptr_r + CW'(1);
        end else begin
          phase_r <= 1'b1;
          ptr_r   <= '0;
        end
      end
      S_MOD: begin
        if (is_exit) begin
          beg_r    <= rec_q.cls_begin[cls];
          diff_r   <= item_r.now_ns - rec_q.cls_begin[cls];
          reason_r <= 3'(cls) + pwit_pkg::REASON_SYSCALL_BASE;
        end else if (!is_enter && phase_r) begin
          beg_r    <= rec_q.switch_begin;
          diff_r   <= item_r.now_ns - rec_q.switch_begin;
          reason_r <= rec_q.pending_reason;
        end else begin
          phase_r <= 1'b1;
          ptr_r   <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      out_r.rec_process    <= target_r;
      out_r.rec_thread     <= key;
      out_r.begin_ns       <= beg_r;
      out_r.finish_ns      <= item_r.now_ns;
      out_r.wait_reason    <= reason_r;
      out_r.rec_cpu        <= item_r.cpu_index;
      out_r.accumulated_ns <= total;
    end
  end

  pwit_table #(
    .SLOTS (THREAD_SLOTS)
  ) u_table (
    .clk       (clk),
    .tid_re    (tid_re),
    .tid_raddr (tid_raddr),
    .tid_q     (tid_q),
    .tid_we    (tid_we),
    .tid_waddr (fill_r[AW-1:0]),
    .tid_wdata (item_r.thread_id),
    .rec_re    (rec_re),
    .rec_raddr (slot_r),
    .rec_q     (rec_q),
    .rec_we    (rec_we),
    .rec_waddr (rec_waddr),
    .rec_wdata (rec_wdata)
  );

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the per-thread wait interval tracker: directed and random events.
`default_nettype none
module testbench;

  localparam int N_SLOTS = pwit_pkg::THREAD_SLOTS;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TW = pwit_pkg::TID_W;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  pwit_pkg::in_beat_t in_data;
  pwit_pkg::out_beat_t out_data;
  logic cfg_we, cfg_index;
  logic [pwit_pkg::CFG_W-1:0] cfg_data;

  per_thread_wait_interval_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // thread table mirror
  typedef struct {
    logic [TW-1:0] thread;
    logic [63:0] cls_begin [3];
    logic [63:0] sw_begin;
    logic [2:0] reason;
    logic [63:0] cls_sum [3];
    logic [63:0] off_sum;
  } thread_rec_t;

  thread_rec_t threads [N_SLOTS];
  int n_threads;
  logic [TW-1:0] tracked_proc;
  logic [31:0] min_offcpu;
  pwit_pkg::out_beat_t interval_q [$];

  int mismatches, idle_cycles, records_seen;
  bit hold_rx, quiet;
  logic [63:0] clock_ns;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int find_thread(logic [TW-1:0] tid);
    for (int i = 0; i < n_threads; i++)
      if (threads[i].thread == tid) return i;
    return -1;
  endfunction

  // advance the mirror by one event, queue any closed interval
  task automatic track_event(pwit_pkg::in_beat_t ev);
    int s;
    pwit_pkg::out_beat_t r;
    logic [63:0] dur;
    if (tracked_proc == 0) return;
    if (ev.mode == pwit_pkg::MODE_ENTER || ev.mode == pwit_pkg::MODE_EXIT) begin
      if (ev.proc_id != tracked_proc || ev.wait_class == pwit_pkg::CLASS_NONE) return;
      s = find_thread(ev.thread_id);
      if (ev.mode == pwit_pkg::MODE_ENTER) begin
        if (s < 0) begin
          if (n_threads >= N_SLOTS) return;
          s = n_threads++;
          threads[s].thread = ev.thread_id;
          for (int c = 0; c < 3; c++) begin
            threads[s].cls_begin[c] = 0;
            threads[s].cls_sum[c] = 0;
          end
          threads[s].sw_begin = 0;
          threads[s].reason = pwit_pkg::REASON_NONE;
          threads[s].off_sum = 0;
        end
        threads[s].cls_begin[ev.wait_class] = ev.now_ns;
        threads[s].reason = 3'(ev.wait_class) + pwit_pkg::REASON_SYSCALL_BASE;
        return;
      end
      if (s < 0 || threads[s].cls_begin[ev.wait_class] == 0) return;
      threads[s].cls_sum[ev.wait_class] += ev.now_ns - threads[s].cls_begin[ev.wait_class];
      r = '{tracked_proc, ev.thread_id, threads[s].cls_begin[ev.wait_class], ev.now_ns,
            3'(ev.wait_class) + pwit_pkg::REASON_SYSCALL_BASE, ev.cpu_index,
            threads[s].cls_sum[ev.wait_class]};
      interval_q.push_back(r);
      threads[s].cls_begin[ev.wait_class] = 0;
      threads[s].reason = pwit_pkg::REASON_NONE;
      return;
    end
    if (ev.mode != pwit_pkg::MODE_SWITCH) return;
    s = find_thread(ev.outgoing_tid);
    if (s >= 0) begin
      threads[s].sw_begin = ev.now_ns;
      if (threads[s].reason == pwit_pkg::REASON_NONE) threads[s].reason = pwit_pkg::REASON_SCHED;
    end
    s = find_thread(ev.incoming_tid);
    if (s < 0 || threads[s].sw_begin == 0) return;
    dur = ev.now_ns - threads[s].sw_begin;
    r = '{tracked_proc, ev.incoming_tid, threads[s].sw_begin, ev.now_ns,
          threads[s].reason, ev.cpu_index, 64'd0};
    threads[s].sw_begin = 0;
    threads[s].reason = pwit_pkg::REASON_NONE;
    if (dur < 64'(min_offcpu)) return;
    threads[s].off_sum += dur;
    r.accumulated_ns = threads[s].off_sum;
    interval_q.push_back(r);
  endtask

  // send one beat, predicting at acceptance; valid stays up until the next idle, register write or drain
  task automatic send_event(pwit_pkg::in_beat_t ev);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_event(ev);
  endtask

  // stop sending, wait until every interval is out and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (interval_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pwit_pkg::CFG_TARGET) tracked_proc = val[TW-1:0];
    else min_offcpu = val;
    @(posedge clk);
  endtask

  function automatic pwit_pkg::in_beat_t mk(logic [1:0] m, logic [TW-1:0] p,
                                            logic [TW-1:0] t, logic [1:0] c,
                                            logic [TW-1:0] o, logic [TW-1:0] i,
                                            logic [63:0] ts);
    pwit_pkg::in_beat_t e;
    e = '{m, p, t, c, o, i, ts, 12'($urandom)};
    return e;
  endfunction

  // result checker
  always @(posedge clk) begin
    pwit_pkg::out_beat_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      records_seen++;
      if (interval_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %p", out_data);
      end else begin
        exp_r = interval_q.pop_front();
        if (exp_r !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("record differs: exp %p got %p", exp_r, out_data);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= hold_rx || (!quiet && $urandom_range(99) < 28);
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("per_thread_wait_interval_tracker: mismatch");
      $finish;
    end
  end

  // disabled tracking, foreign process, unused codes, zero stamps, same thread
  task automatic test_directed();
    pwit_pkg::in_beat_t e;
    send_event(mk(pwit_pkg::MODE_ENTER, 23'd5, 23'd1, 2'd0, '0, '0, 64'd10));
    write_reg(pwit_pkg::CFG_TARGET, 32'h7FFFFF);
    write_reg(pwit_pkg::CFG_MIN, 32'd0);
    send_event(mk(pwit_pkg::MODE_ENTER, 23'h7FFFFF, 23'h7FFFFF, 2'd0, '0, '0, 64'd100));
    send_event(mk(pwit_pkg::MODE_EXIT, 23'h7FFFFF, 23'h7FFFFF, 2'd0, '0, '0,
                  64'hFFFF_FFFF_FFFF_FFFF));
    send_event(mk(pwit_pkg::MODE_ENTER, 23'd3, 23'd0, 2'd1, '0, '0, 64'd5));
    send_event(mk(pwit_pkg::MODE_ENTER, 23'h7FFFFF, 23'd0, 2'd1, '0, '0, 64'd5));
    send_event(mk(pwit_pkg::MODE_ENTER, 23'h7FFFFF, 23'd0, pwit_pkg::CLASS_NONE, '0, '0,
                  64'd6));
    send_event(mk(pwit_pkg::MODE_EXIT, 23'h7FFFFF, 23'd0, pwit_pkg::CLASS_NONE, '0, '0,
                  64'd7));
    send_event(mk(2'd3, 23'h7FFFFF, 23'd0, 2'd1, '0, '0, 64'd8));
    send_event(mk(pwit_pkg::MODE_EXIT, 23'h7FFFFF, 23'd0, 2'd2, '0, '0, 64'd9));
    send_event(mk(pwit_pkg::MODE_EXIT, 23'h7FFFFF, 23'd0, 2'd1, '0, '0, 64'd50));
    send_event(mk(pwit_pkg::MODE_ENTER, 23'h7FFFFF, 23'd0, 2'd2, '0, '0, 64'd0));
    send_event(mk(pwit_pkg::MODE_EXIT, 23'h7FFFFF, 23'd0, 2'd2, '0, '0, 64'd60));
    send_event(mk(pwit_pkg::MODE_ENTER, 23'h7FFFFF, 23'd0, 2'd2, '0, '0, 64'd61));
    send_event(mk(pwit_pkg::MODE_SWITCH, '0, '0, 2'd0, 23'd0, 23'd0, 64'd70));
    send_event(mk(pwit_pkg::MODE_SWITCH, '0, '0, 2'd0, 23'd0, 23'd9, 64'd80));
    send_event(mk(pwit_pkg::MODE_SWITCH, '0, '0, 2'd0, 23'd9, 23'd0, 64'd200));
    send_event(mk(pwit_pkg::MODE_SWITCH, '0, '0, 2'd0, 23'd0, 23'd0, 64'd0));
    send_event(mk(pwit_pkg::MODE_SWITCH, '0, '0, 2'd0, 23'h7FFFFF, 23'h7FFFFF, 64'd300));
    drain();
    write_reg(pwit_pkg::CFG_MIN, 32'hFFFF_FFFF);
    send_event(mk(pwit_pkg::MODE_SWITCH, '0, '0, 2'd0, 23'd0, 23'd9, 64'd400));
    e = mk(pwit_pkg::MODE_SWITCH, '0, '0, 2'd0, 23'd9, 23'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    e.cpu_index = 12'hFFF;
    send_event(e);
    drain();
  endtask

  // random events for one process over a small pool of threads
  task automatic test_random(int n, logic [TW-1:0] proc, logic [31:0] min_ns);
    pwit_pkg::in_beat_t e;
    int pick;
    logic [TW-1:0] flip;
    write_reg(pwit_pkg::CFG_TARGET, 32'(proc));
    write_reg(pwit_pkg::CFG_MIN, min_ns);
    for (int k = 0; k < n; k++) begin
      clock_ns += 64'($urandom_range(400000));
      quiet = (k > n / 2 && k < n / 2 + 150);
      pick = $urandom_range(99);
      flip = k[0] ? 23'h400000 : 23'd0;
      e = mk(2'($urandom_range(2)), proc, 23'($urandom_range(12)) ^ flip,
             2'($urandom_range(2)), 23'($urandom_range(12)), 23'($urandom_range(12)),
             clock_ns);
      if (e.mode == pwit_pkg::MODE_SWITCH) begin
        e.outgoing_tid ^= flip;
        e.incoming_tid ^= flip;
      end
      if (pick < 8) e = '{2'($urandom), 23'($urandom), 23'($urandom), 2'($urandom),
                          23'($urandom), 23'($urandom), {$urandom, $urandom}, 12'($urandom)};
      else if (pick < 12) e.proc_id = 23'($urandom);
      send_event(e);
    end
    quiet = 0;
    drain();
  endtask

  // receiver holds off while events keep coming
  task automatic test_backpressure();
    pwit_pkg::in_beat_t e;
    hold_rx = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      for (int k = 0; k < 40; k++) begin
        clock_ns += 64'd1000;
        e = mk(k[0] ? pwit_pkg::MODE_EXIT : pwit_pkg::MODE_ENTER, tracked_proc,
               23'(k / 2 % 4), 2'd1, '0, '0, clock_ns);
        send_event(e);
      end
    join
    drain();
  endtask

  // fill the table, then a new thread must be ignored
  task automatic test_table_full();
    write_reg(pwit_pkg::CFG_TARGET, 32'd77);
    for (int k = n_threads; k <= N_SLOTS; k++)
      send_event(mk(pwit_pkg::MODE_ENTER, 23'd77, 23'h100000 + 23'(k), 2'd0, '0, '0, 64'd1));
    send_event(mk(pwit_pkg::MODE_EXIT, 23'd77, 23'h100000 + 23'(N_SLOTS), 2'd0, '0, '0,
                  64'd9));
    send_event(mk(pwit_pkg::MODE_EXIT, 23'd77, 23'h100000 + 23'(N_SLOTS - 1), 2'd0, '0, '0,
                  64'd9));
    drain();
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = 0; cfg_data = '0;
    out_stall = 0; hold_rx = 0; quiet = 0;
    mismatches = 0; idle_cycles = 0; records_seen = 0; n_threads = 0;
    tracked_proc = 0; min_offcpu = 32'd100000; clock_ns = 64'd1000;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(400, 23'h000123, 32'd100000);
    test_backpressure();
    test_random(400, 23'h7FFFFF, 32'd0);
    test_random(300, 23'h000001, 32'd200000);
    test_table_full();
    if (mismatches == 0 && interval_q.size() == 0)
      $display("per_thread_wait_interval_tracker: match");
    else
      $display("per_thread_wait_interval_tracker: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/pwit_pkg.sv
rtl/pwit_table.sv
rtl/per_thread_wait_interval_tracker.sv
sim/testbench.sv
